FILE: sv/pdfmsc_pkg.sv
// ----------------------------------------------------------------------------
// pdfmsc_pkg: shared types, codes and microprogram of the spring follower
// Holds the control word layout, the operation and operand codes, the
// configuration register indexes and the read-only microprogram.
// ----------------------------------------------------------------------------
package pdfmsc_pkg;

    localparam int DT_BITS      = 16;
    localparam int GAIN_BITS    = 32;
    localparam int MS_BITS      = 31;
    localparam int LF_BITS      = 17;
    localparam int CFG_IDX_BITS = 3;
    localparam int STEP_BITS    = 6;

    localparam logic [CFG_IDX_BITS-1:0] REG_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_TIME = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SPEED = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEAD      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_POS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_VEL = 3'd6;

    localparam logic [DT_BITS-1:0] DT_RESET = 16'd1092;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_MUL    = 3'd1;
    localparam logic [2:0] OP_RND    = 3'd2;
    localparam logic [2:0] OP_ADD    = 3'd3;
    localparam logic [2:0] OP_SUB    = 3'd4;
    localparam logic [2:0] OP_DIFF   = 3'd5;
    localparam logic [2:0] OP_TOWARD = 3'd6;

    localparam logic [3:0] SRC_ZERO  = 4'd0;
    localparam logic [3:0] SRC_POS   = 4'd1;
    localparam logic [3:0] SRC_VEL   = 4'd2;
    localparam logic [3:0] SRC_TP    = 4'd3;
    localparam logic [3:0] SRC_TV    = 4'd4;
    localparam logic [3:0] SRC_LEAD  = 4'd5;
    localparam logic [3:0] SRC_V0    = 4'd6;
    localparam logic [3:0] SRC_TVR   = 4'd7;
    localparam logic [3:0] SRC_PROD  = 4'd8;
    localparam logic [3:0] SRC_ACC   = 4'd9;
    localparam logic [3:0] SRC_X1    = 4'd10;
    localparam logic [3:0] SRC_SMALL = 4'd11;
    localparam logic [3:0] SRC_MS    = 4'd12;
    localparam logic [3:0] SRC_DIFF  = 4'd13;

    localparam logic [3:0] DST_NONE  = 4'd0;
    localparam logic [3:0] DST_POS   = 4'd1;
    localparam logic [3:0] DST_VEL   = 4'd2;
    localparam logic [3:0] DST_LEAD  = 4'd3;
    localparam logic [3:0] DST_V0    = 4'd4;
    localparam logic [3:0] DST_TVR   = 4'd5;
    localparam logic [3:0] DST_PROD  = 4'd6;
    localparam logic [3:0] DST_ACC   = 4'd7;
    localparam logic [3:0] DST_X1    = 4'd8;
    localparam logic [3:0] DST_SMALL = 4'd9;

    localparam logic [1:0] MB_SG = 2'd0;
    localparam logic [1:0] MB_DG = 2'd1;
    localparam logic [1:0] MB_DT = 2'd2;
    localparam logic [1:0] MB_LF = 2'd3;

    localparam logic SH_GAIN = 1'b0;
    localparam logic SH_DT   = 1'b1;

    localparam logic [1:0] JMP_NONE   = 2'd0;
    localparam logic [1:0] JMP_ALWAYS = 2'd1;
    localparam logic [1:0] JMP_IF_FAR = 2'd2;

    localparam logic [1:0] MODE_SPRING = 2'd0;
    localparam logic [1:0] MODE_SNAP   = 2'd1;
    localparam logic [1:0] MODE_MIN    = 2'd2;

    localparam logic [STEP_BITS-1:0] STEP_FIRST  = 6'd0;
    localparam logic [STEP_BITS-1:0] STEP_MIN    = 6'd25;
    localparam logic [STEP_BITS-1:0] STEP_SPRING = 6'd27;
    localparam logic [STEP_BITS-1:0] STEP_LEAD   = 6'd29;

    typedef struct packed {
        logic [2:0]           op;
        logic [3:0]           src_a;
        logic [3:0]           src_b;
        logic [1:0]           mul_b;
        logic                 shf;
        logic [3:0]           dst;
        logic                 mode_we;
        logic [1:0]           mode;
        logic [1:0]           jmp;
        logic [STEP_BITS-1:0] target;
        logic                 last;
    } ctrl_word_t;

    typedef struct packed {
        logic       start;
        logic       exec;
        ctrl_word_t cw;
    } seq_ctrl_t;

    typedef struct packed {
        logic near;
        logic out_valid;
    } dp_status_t;

    function automatic ctrl_word_t make_cw(
        input logic [2:0]           op,
        input logic [3:0]           src_a,
        input logic [3:0]           src_b,
        input logic [1:0]           mul_b,
        input logic                 shf,
        input logic [3:0]           dst,
        input logic                 mode_we,
        input logic [1:0]           mode,
        input logic [1:0]           jmp,
        input logic [STEP_BITS-1:0] target,
        input logic                 last
    );
        ctrl_word_t w;
        w.op      = op;
        w.src_a   = src_a;
        w.src_b   = src_b;
        w.mul_b   = mul_b;
        w.shf     = shf;
        w.dst     = dst;
        w.mode_we = mode_we;
        w.mode    = mode;
        w.jmp     = jmp;
        w.target  = target;
        w.last    = last;
        return w;
    endfunction

    // Each multiply takes two steps: the raw product, then rounding and clipping.
    function automatic ctrl_word_t ucode(input logic [STEP_BITS-1:0] step);
        ctrl_word_t w;
        case (step)
            6'd0:  w = make_cw(OP_MUL, SRC_TV, SRC_ZERO, MB_LF, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd1:  w = make_cw(OP_RND, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_LEAD,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd2:  w = make_cw(OP_SUB, SRC_VEL, SRC_LEAD, MB_SG, SH_DT, DST_V0,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd3:  w = make_cw(OP_SUB, SRC_TV, SRC_LEAD, MB_SG, SH_DT, DST_TVR,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd4:  w = make_cw(OP_DIFF, SRC_TP, SRC_POS, MB_SG, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd5:  w = make_cw(OP_MUL, SRC_DIFF, SRC_ZERO, MB_SG, SH_GAIN, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd6:  w = make_cw(OP_RND, SRC_ZERO, SRC_ZERO, MB_SG, SH_GAIN, DST_PROD,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd7:  w = make_cw(OP_DIFF, SRC_TVR, SRC_V0, MB_SG, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd8:  w = make_cw(OP_MUL, SRC_DIFF, SRC_ZERO, MB_DG, SH_GAIN, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd9:  w = make_cw(OP_RND, SRC_ZERO, SRC_ZERO, MB_SG, SH_GAIN, DST_ACC,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd10: w = make_cw(OP_ADD, SRC_PROD, SRC_ACC, MB_SG, SH_DT, DST_ACC,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd11: w = make_cw(OP_MUL, SRC_ACC, SRC_ZERO, MB_DT, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd12: w = make_cw(OP_RND, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_PROD,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd13: w = make_cw(OP_ADD, SRC_V0, SRC_PROD, MB_SG, SH_DT, DST_ACC,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd14: w = make_cw(OP_MUL, SRC_ACC, SRC_ZERO, MB_DT, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd15: w = make_cw(OP_RND, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_PROD,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd16: w = make_cw(OP_ADD, SRC_POS, SRC_PROD, MB_SG, SH_DT, DST_X1,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd17: w = make_cw(OP_MUL, SRC_MS, SRC_ZERO, MB_DT, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd18: w = make_cw(OP_RND, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_SMALL,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd19: w = make_cw(OP_DIFF, SRC_X1, SRC_POS, MB_SG, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd20: w = make_cw(OP_NOP, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_IF_FAR, STEP_SPRING, 1'b0);
            6'd21: w = make_cw(OP_DIFF, SRC_POS, SRC_TP, MB_SG, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd22: w = make_cw(OP_NOP, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_IF_FAR, STEP_MIN, 1'b0);
            6'd23: w = make_cw(OP_ADD, SRC_TP, SRC_ZERO, MB_SG, SH_DT, DST_POS,
                               1'b1, MODE_SNAP, JMP_NONE, STEP_FIRST, 1'b0);
            6'd24: w = make_cw(OP_ADD, SRC_TVR, SRC_ZERO, MB_SG, SH_DT, DST_VEL,
                               1'b0, MODE_SNAP, JMP_ALWAYS, STEP_LEAD, 1'b0);
            6'd25: w = make_cw(OP_TOWARD, SRC_POS, SRC_SMALL, MB_SG, SH_DT, DST_POS,
                               1'b1, MODE_MIN, JMP_NONE, STEP_FIRST, 1'b0);
            6'd26: w = make_cw(OP_TOWARD, SRC_ZERO, SRC_MS, MB_SG, SH_DT, DST_VEL,
                               1'b0, MODE_MIN, JMP_ALWAYS, STEP_LEAD, 1'b0);
            6'd27: w = make_cw(OP_ADD, SRC_X1, SRC_ZERO, MB_SG, SH_DT, DST_POS,
                               1'b1, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd28: w = make_cw(OP_ADD, SRC_ACC, SRC_ZERO, MB_SG, SH_DT, DST_VEL,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd29: w = make_cw(OP_ADD, SRC_VEL, SRC_LEAD, MB_SG, SH_DT, DST_VEL,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd30: w = make_cw(OP_MUL, SRC_LEAD, SRC_ZERO, MB_DT, SH_DT, DST_NONE,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd31: w = make_cw(OP_RND, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_PROD,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b0);
            6'd32: w = make_cw(OP_ADD, SRC_POS, SRC_PROD, MB_SG, SH_DT, DST_POS,
                               1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b1);
            default: w = make_cw(OP_NOP, SRC_ZERO, SRC_ZERO, MB_SG, SH_DT, DST_NONE,
                                 1'b0, MODE_SPRING, JMP_NONE, STEP_FIRST, 1'b1);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/pdfmsc_if.sv
// ----------------------------------------------------------------------------
// pdfmsc_if: channel interfaces of the spring follower
// Target input stream, result output stream and register write channel.
// ----------------------------------------------------------------------------
interface pdfmsc_in_if #(parameter int VALUE_BITS = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] target_position;
    logic signed [VALUE_BITS-1:0] target_velocity;

    modport source (output valid, target_position, target_velocity, input ready);
    modport sink (input valid, target_position, target_velocity, output ready);
endinterface

interface pdfmsc_out_if #(parameter int VALUE_BITS = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] new_position;
    logic signed [VALUE_BITS-1:0] new_velocity;
    logic [1:0]                   step_mode;
    logic                         saturated;

    modport source (output valid, new_position, new_velocity, step_mode, saturated,
                    input ready);
    modport sink (input valid, new_position, new_velocity, step_mode, saturated,
                  output ready);
endinterface

interface pdfmsc_cfg_if #(parameter int DATA_BITS = 32) ();
    logic                                   valid;
    logic                                   ready;
    logic [pdfmsc_pkg::CFG_IDX_BITS-1:0]    index;
    logic [DATA_BITS-1:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/pd_follow_min_speed_clamp.sv
// ----------------------------------------------------------------------------
// pd_follow_min_speed_clamp: PD spring follower with minimum approach speed
// Advances a stored position and velocity toward a target once per beat on
// the target channel, with an intercept lead and saturating fixed point.
//
// Usage:
//   target: one beat carries target_position and target_velocity.
//   result: one beat per target beat with new_position, new_velocity,
//           step_mode and saturated.
//   cfg:    register writes, always ready; index 5 and 6 load the state.
//           Write only while no target beat is in flight.
// Timing:
//   A target beat starts a microprogram of 27 steps (spring step) or 29 steps
//   (snap or minimum speed step), one step per cycle unless the last step
//   waits, on a single shared multiplier and saturating adder. The last step
//   loads the result register, and a new target beat is taken in the cycle
//   after the last step, so target beats do not overlap.
//   The result is held in an output register; the next target is accepted
//   while it waits. If it is still not taken when the next item finishes,
//   the last step waits.
//   Reset clears the state and loads the register reset values.
// ----------------------------------------------------------------------------
module pd_follow_min_speed_clamp #(
    parameter int VALUE_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pdfmsc_in_if.sink     target,
    pdfmsc_out_if.source  result,
    pdfmsc_cfg_if.sink    cfg
);

    pdfmsc_pkg::seq_ctrl_t  ctrl;
    pdfmsc_pkg::dp_status_t status;

    pdfmsc_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (target.valid),
        .in_ready  (target.ready),
        .out_ready (result.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    pdfmsc_datapath #(
        .VALUE_BITS    (VALUE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .tp_in        (target.target_position),
        .tv_in        (target.target_velocity),
        .out_ready    (result.ready),
        .out_position (result.new_position),
        .out_velocity (result.new_velocity),
        .out_mode     (result.step_mode),
        .out_sat      (result.saturated)
    );

    assign cfg.ready    = 1'b1;
    assign result.valid = status.out_valid;

endmodule

FILE: sv/pdfmsc_sequencer.sv
// ----------------------------------------------------------------------------
// pdfmsc_sequencer: microprogram step counter
// Fetches one control word per step, takes jumps and holds the final step
// while the result register is still occupied.
// ----------------------------------------------------------------------------
module pdfmsc_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   out_ready,
    input  pdfmsc_pkg::dp_status_t status,
    output pdfmsc_pkg::seq_ctrl_t  ctrl
);

    logic                             busy_reg;
    logic [pdfmsc_pkg::STEP_BITS-1:0] step_reg;
    logic [pdfmsc_pkg::STEP_BITS-1:0] step_next;
    pdfmsc_pkg::ctrl_word_t           cw;
    logic                             stall;
    logic                             take_jump;

    always_comb
    begin
        cw    = pdfmsc_pkg::ucode(step_reg);
        stall = cw.last && status.out_valid && !out_ready;
        case (cw.jmp)
            pdfmsc_pkg::JMP_ALWAYS: take_jump = 1'b1;
            pdfmsc_pkg::JMP_IF_FAR: take_jump = !status.near;
            default:                take_jump = 1'b0;
        endcase
        step_next  = take_jump ? cw.target : step_reg + 1'b1;
        in_ready   = !busy_reg;
        ctrl.start = in_valid && !busy_reg;
        ctrl.exec  = busy_reg && !stall;
        ctrl.cw    = cw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= pdfmsc_pkg::STEP_FIRST;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= pdfmsc_pkg::STEP_FIRST;
        end
        else if (ctrl.exec)
        begin
            if (cw.last)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_next;
        end
    end

endmodule

FILE: sv/pdfmsc_datapath.sv
// ----------------------------------------------------------------------------
// pdfmsc_datapath: registers, shared multiplier and saturating adder
// Executes one control word per cycle while not stalled, holds the configuration registers,
// the follower state and the result register.
// ----------------------------------------------------------------------------
module pdfmsc_datapath #(
    parameter int VALUE_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pdfmsc_pkg::seq_ctrl_t               ctrl,
    output pdfmsc_pkg::dp_status_t              status,
    input  logic                                cfg_we,
    input  logic [pdfmsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [((VALUE_BITS > 32) ? VALUE_BITS : 32)-1:0] cfg_data,
    input  logic signed [VALUE_BITS-1:0]        tp_in,
    input  logic signed [VALUE_BITS-1:0]        tv_in,
    input  logic                                out_ready,
    output logic signed [VALUE_BITS-1:0]        out_position,
    output logic signed [VALUE_BITS-1:0]        out_velocity,
    output logic [1:0]                          out_mode,
    output logic                                out_sat
);

    localparam int VB  = VALUE_BITS;
    localparam int OPW = VB + 1;
    localparam int GB  = pdfmsc_pkg::GAIN_BITS;
    localparam int PW  = OPW + GB;
    localparam int RW  = PW + 1;
    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic [RW-1:0] RND_GAIN = RW'(1) << (FRACTION_BITS - 1);
    localparam logic [RW-1:0] RND_DT   = RW'(1) << (pdfmsc_pkg::DT_BITS - 1);

    logic [GB-1:0]                      sg_reg;
    logic [GB-1:0]                      dg_reg;
    logic [pdfmsc_pkg::DT_BITS-1:0]     dt_reg;
    logic [pdfmsc_pkg::MS_BITS-1:0]     ms_reg;
    logic [pdfmsc_pkg::LF_BITS-1:0]     lf_reg;
    logic signed [VB-1:0]               pos_reg;
    logic signed [VB-1:0]               vel_reg;
    logic signed [VB-1:0]               tp_reg;
    logic signed [VB-1:0]               tv_reg;
    logic signed [VB-1:0]               lead_reg;
    logic signed [VB-1:0]               v0_reg;
    logic signed [VB-1:0]               tvr_reg;
    logic signed [VB-1:0]               prod_reg;
    logic signed [VB-1:0]               acc_reg;
    logic signed [VB-1:0]               x1_reg;
    logic signed [VB-1:0]               small_reg;
    logic signed [OPW-1:0]              diff_reg;
    logic [PW-1:0]                      mul_reg;
    logic                               mul_neg_reg;
    logic                               mul_shf_reg;
    logic                               clip_reg;
    logic [1:0]                         mode_reg;
    logic                               out_valid_reg;
    logic signed [VB-1:0]               out_pos_reg;
    logic signed [VB-1:0]               out_vel_reg;
    logic [1:0]                         out_mode_reg;
    logic                               out_sat_reg;

    pdfmsc_pkg::ctrl_word_t             cw;
    logic                               ms_clip;
    logic signed [VB-1:0]               ms_val;
    logic signed [OPW-1:0]              opa;
    logic signed [OPW-1:0]              opb;
    logic [OPW-1:0]                     mag_a;
    logic [GB-1:0]                      mulb;
    logic [PW-1:0]                      mul_next;
    logic [RW-1:0]                      rnd_sum;
    logic [RW-1:0]                      rnd_q;
    logic [RW-1:0]                      rnd_lim;
    logic                               rnd_clip;
    logic [VB-1:0]                      rnd_mag;
    logic signed [VB-1:0]               rnd_res;
    logic signed [OPW-1:0]              sum;
    logic                               alu_ovf;
    logic signed [VB-1:0]               alu_res;
    logic signed [VB-1:0]               wb;
    logic                               wb_clip;
    logic                               clip_op;
    logic signed [OPW:0]                near_d;
    logic signed [OPW:0]                near_s;
    logic signed [OPW:0]                near_sum;

    assign cw = ctrl.cw;

    always_comb
    begin
        ms_clip = |(ms_reg >> (VB - 1));
        ms_val  = ms_clip ? VMAX : VB'(ms_reg);

        case (cw.src_a)
            pdfmsc_pkg::SRC_POS:   opa = OPW'(pos_reg);
            pdfmsc_pkg::SRC_VEL:   opa = OPW'(vel_reg);
            pdfmsc_pkg::SRC_TP:    opa = OPW'(tp_reg);
            pdfmsc_pkg::SRC_TV:    opa = OPW'(tv_reg);
            pdfmsc_pkg::SRC_LEAD:  opa = OPW'(lead_reg);
            pdfmsc_pkg::SRC_V0:    opa = OPW'(v0_reg);
            pdfmsc_pkg::SRC_TVR:   opa = OPW'(tvr_reg);
            pdfmsc_pkg::SRC_PROD:  opa = OPW'(prod_reg);
            pdfmsc_pkg::SRC_ACC:   opa = OPW'(acc_reg);
            pdfmsc_pkg::SRC_X1:    opa = OPW'(x1_reg);
            pdfmsc_pkg::SRC_SMALL: opa = OPW'(small_reg);
            pdfmsc_pkg::SRC_MS:    opa = OPW'(ms_val);
            pdfmsc_pkg::SRC_DIFF:  opa = diff_reg;
            default:               opa = '0;
        endcase

        case (cw.src_b)
            pdfmsc_pkg::SRC_POS:   opb = OPW'(pos_reg);
            pdfmsc_pkg::SRC_VEL:   opb = OPW'(vel_reg);
            pdfmsc_pkg::SRC_TP:    opb = OPW'(tp_reg);
            pdfmsc_pkg::SRC_TV:    opb = OPW'(tv_reg);
            pdfmsc_pkg::SRC_LEAD:  opb = OPW'(lead_reg);
            pdfmsc_pkg::SRC_V0:    opb = OPW'(v0_reg);
            pdfmsc_pkg::SRC_TVR:   opb = OPW'(tvr_reg);
            pdfmsc_pkg::SRC_PROD:  opb = OPW'(prod_reg);
            pdfmsc_pkg::SRC_ACC:   opb = OPW'(acc_reg);
            pdfmsc_pkg::SRC_X1:    opb = OPW'(x1_reg);
            pdfmsc_pkg::SRC_SMALL: opb = OPW'(small_reg);
            pdfmsc_pkg::SRC_MS:    opb = OPW'(ms_val);
            pdfmsc_pkg::SRC_DIFF:  opb = diff_reg;
            default:               opb = '0;
        endcase

        case (cw.mul_b)
            pdfmsc_pkg::MB_SG: mulb = sg_reg;
            pdfmsc_pkg::MB_DG: mulb = dg_reg;
            pdfmsc_pkg::MB_DT: mulb = GB'(dt_reg);
            pdfmsc_pkg::MB_LF: mulb = GB'(lf_reg);
            default:           mulb = '0;
        endcase

        // The product is formed on the magnitude; the sign is applied after rounding.
        mag_a    = opa[OPW-1] ? $unsigned(-opa) : $unsigned(opa);
        mul_next = PW'(mag_a) * PW'(mulb);

        rnd_sum  = {1'b0, mul_reg} + ((mul_shf_reg == pdfmsc_pkg::SH_DT) ? RND_DT : RND_GAIN);
        rnd_q    = (mul_shf_reg == pdfmsc_pkg::SH_DT) ? (rnd_sum >> pdfmsc_pkg::DT_BITS)
                                                      : (rnd_sum >> FRACTION_BITS);
        rnd_lim  = RW'($unsigned(VMAX)) + RW'(mul_neg_reg);
        rnd_clip = rnd_q > rnd_lim;
        rnd_mag  = rnd_clip ? rnd_lim[VB-1:0] : rnd_q[VB-1:0];
        rnd_res  = mul_neg_reg ? $signed(-rnd_mag) : $signed(rnd_mag);

        case (cw.op)
            pdfmsc_pkg::OP_SUB:    sum = opa - opb;
            pdfmsc_pkg::OP_TOWARD: sum = diff_reg[OPW-1] ? (opa + opb) : (opa - opb);
            default:               sum = opa + opb;
        endcase
        alu_ovf = sum[OPW-1] != sum[VB-1];
        alu_res = alu_ovf ? (sum[OPW-1] ? VMIN : VMAX) : sum[VB-1:0];

        wb      = (cw.op == pdfmsc_pkg::OP_RND) ? rnd_res : alu_res;
        wb_clip = (cw.op == pdfmsc_pkg::OP_RND) ? rnd_clip : alu_ovf;
        clip_op = (cw.op == pdfmsc_pkg::OP_RND) || (cw.op == pdfmsc_pkg::OP_ADD) ||
                  (cw.op == pdfmsc_pkg::OP_SUB) || (cw.op == pdfmsc_pkg::OP_TOWARD);

        // The step is within reach when -small <= diff <= small.
        near_d   = (OPW + 1)'(diff_reg);
        near_s   = (OPW + 1)'(small_reg);
        near_sum = near_d + near_s;
        status.near      = (near_d <= near_s) && !near_sum[OPW];
        status.out_valid = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_reg        <= '0;
            dg_reg        <= '0;
            dt_reg        <= pdfmsc_pkg::DT_RESET;
            ms_reg        <= '0;
            lf_reg        <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pdfmsc_pkg::REG_STIFFNESS: sg_reg  <= cfg_data[GB-1:0];
                    pdfmsc_pkg::REG_DAMPING:   dg_reg  <= cfg_data[GB-1:0];
                    pdfmsc_pkg::REG_STEP_TIME: dt_reg  <= cfg_data[pdfmsc_pkg::DT_BITS-1:0];
                    pdfmsc_pkg::REG_MIN_SPEED: ms_reg  <= cfg_data[pdfmsc_pkg::MS_BITS-1:0];
                    pdfmsc_pkg::REG_LEAD:      lf_reg  <= cfg_data[pdfmsc_pkg::LF_BITS-1:0];
                    pdfmsc_pkg::REG_START_POS: pos_reg <= $signed(cfg_data[VB-1:0]);
                    pdfmsc_pkg::REG_START_VEL: vel_reg <= $signed(cfg_data[VB-1:0]);
                    default:                   ;
                endcase
            end
            if (ctrl.exec && (cw.dst == pdfmsc_pkg::DST_POS))
            begin
                pos_reg <= wb;
            end
            if (ctrl.exec && (cw.dst == pdfmsc_pkg::DST_VEL))
            begin
                vel_reg <= wb;
            end
            if (ctrl.exec && cw.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            tp_reg   <= tp_in;
            tv_reg   <= tv_in;
            clip_reg <= ms_clip;
        end
        else if (ctrl.exec && clip_op && wb_clip)
        begin
            clip_reg <= 1'b1;
        end

        if (ctrl.exec)
        begin
            case (cw.dst)
                pdfmsc_pkg::DST_LEAD:  lead_reg  <= wb;
                pdfmsc_pkg::DST_V0:    v0_reg    <= wb;
                pdfmsc_pkg::DST_TVR:   tvr_reg   <= wb;
                pdfmsc_pkg::DST_PROD:  prod_reg  <= wb;
                pdfmsc_pkg::DST_ACC:   acc_reg   <= wb;
                pdfmsc_pkg::DST_X1:    x1_reg    <= wb;
                pdfmsc_pkg::DST_SMALL: small_reg <= wb;
                default:               ;
            endcase
            if (cw.op == pdfmsc_pkg::OP_DIFF)
            begin
                diff_reg <= opa - opb;
            end
            if (cw.op == pdfmsc_pkg::OP_MUL)
            begin
                mul_reg     <= mul_next;
                mul_neg_reg <= opa[OPW-1];
                mul_shf_reg <= cw.shf;
            end
            if (cw.mode_we)
            begin
                mode_reg <= cw.mode;
            end
            if (cw.last)
            begin
                out_pos_reg  <= wb;
                out_vel_reg  <= vel_reg;
                out_mode_reg <= mode_reg;
                out_sat_reg  <= clip_reg || (clip_op && wb_clip);
            end
        end
    end

    assign out_position = out_pos_reg;
    assign out_velocity = out_vel_reg;
    assign out_mode     = out_mode_reg;
    assign out_sat      = out_sat_reg;

endmodule
